[design/magnetometer_trim_compensation_core_assert.svh]
// assertion macros for the magnetometer trim compensation core
`ifndef MAGNETOMETER_TRIM_COMPENSATION_CORE_ASSERT_SVH
`define MAGNETOMETER_TRIM_COMPENSATION_CORE_ASSERT_SVH
`ifndef SYNTH
`define MTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MTC_ASSERT_IMP(lbl, ante, cons, msg)
`define MTC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[design/mtc_pkg.sv]
// shared types and constants of the magnetometer trim compensation core
`timescale 1ns / 1ps
package mtc_pkg;
  localparam int RAW_XY_W   = 13;
  localparam int RAW_Z_W    = 15;
  localparam int HALL_W     = 14;
  localparam int OUT_W      = 21;
  localparam int FLAG_W     = 3;
  localparam int REG_W      = 16;
  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int H2_W       = 28;
  localparam int ZDEN_W     = 31;

  typedef logic [REG_W-1:0] cfg_reg_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_XY_OFFSETS,
    REG_XY_GAINS,
    REG_XY_CURVATURE,
    REG_HALL_REFERENCE,
    REG_Z_HALL_SLOPE,
    REG_Z_DIVISOR_BASE,
    REG_Z_HALL_OFFSET_GAIN,
    REG_Z_OFFSET
  } reg_idx_t;

  localparam logic signed [RAW_XY_W-1:0] XY_OVF_CODE = 13'sh1000;
  localparam logic signed [RAW_Z_W-1:0]  Z_OVF_CODE  = 15'sh4000;
  localparam logic signed [OUT_W-1:0]    OUT_MAX     = 21'sh0FFFFF;
  localparam logic signed [OUT_W-1:0]    OUT_MIN     = 21'sh100000;
  localparam logic signed [10:0]         GAIN_BIAS   = 11'sd160;

  typedef struct packed {
    logic neg;
    logic zero;
  } mtc_side_t;
endpackage

[design/mtc_if.sv]
// valid/ready stream interfaces for readings and compensated results
`timescale 1ns / 1ps
interface mtc_in_if;
  import mtc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [RAW_XY_W-1:0] raw_x;
  logic signed [RAW_XY_W-1:0] raw_y;
  logic signed [RAW_Z_W-1:0]  raw_z;
  logic [HALL_W-1:0]          hall_resistance;
  modport source (output valid, raw_x, raw_y, raw_z, hall_resistance, input ready);
  modport sink (input valid, raw_x, raw_y, raw_z, hall_resistance, output ready);
endinterface

interface mtc_out_if;
  import mtc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] field_x;
  logic signed [OUT_W-1:0] field_y;
  logic signed [OUT_W-1:0] field_z;
  logic [FLAG_W-1:0]       zeroed_axes;
  modport source (output valid, field_x, field_y, field_z, zeroed_axes, input ready);
  modport sink (input valid, field_x, field_y, field_z, zeroed_axes, output ready);
endinterface

[design/mtc_div.sv]
// pipelined restoring divider, one quotient bit per stage, with overflow detect
`timescale 1ns / 1ps
module mtc_div #(
  parameter int DW = 47,
  parameter int VW = 28,
  parameter int QW = 21
) (
  input  logic               clk,
  input  logic               en,
  input  logic [DW-1:0]      dvd,
  input  logic [VW-1:0]      dvs,
  input  mtc_pkg::mtc_side_t side_in,
  output logic [QW-1:0]      quo,
  output logic               sat,
  output mtc_pkg::mtc_side_t side_out
);
  import mtc_pkg::*;

  localparam int HW = DW - QW;
  localparam int CW = (HW > VW) ? HW : VW;

  logic [CW-1:0] hi_ext;
  logic [CW-1:0] dvs_ext;
  logic [VW-1:0] rem_r  [0:QW-1];
  logic [VW-1:0] dvs_r  [0:QW-1];
  logic [QW-1:0] lq_r   [0:QW];
  logic          sat_r  [0:QW];
  mtc_side_t     side_r [0:QW];
  logic [VW:0]   trial  [1:QW];
  logic [VW:0]   diff   [1:QW];
  logic [QW:1]   take;

  assign hi_ext  = CW'(dvd[DW-1:QW]);
  assign dvs_ext = CW'(dvs);

  always_comb begin
    for (int k = 1; k <= QW; k++) begin
      trial[k] = {rem_r[k-1], lq_r[k-1][QW-1]};
      diff[k]  = trial[k] - {1'b0, dvs_r[k-1]};
      take[k]  = ~diff[k][VW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // quotient fits in QW bits only when the high part is below the divisor
      rem_r[0]  <= hi_ext[VW-1:0];
      dvs_r[0]  <= dvs;
      lq_r[0]   <= dvd[QW-1:0];
      sat_r[0]  <= (hi_ext >= dvs_ext);
      side_r[0] <= side_in;
      for (int k = 1; k <= QW; k++) begin
        if (k < QW) begin
          rem_r[k] <= take[k] ? diff[k][VW-1:0] : trial[k][VW-1:0];
          dvs_r[k] <= dvs_r[k-1];
        end
        lq_r[k]   <= {lq_r[k-1][QW-2:0], take[k]};
        sat_r[k]  <= sat_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign quo      = lq_r[QW];
  assign sat      = sat_r[QW];
  assign side_out = side_r[QW];
endmodule

[design/magnetometer_trim_compensation_core.sv]
// magnetometer trim compensation core: top level
// Turns each raw reading (13-bit signed X and Y, 15-bit signed Z, 14-bit hall
// resistance) into compensated X, Y, Z in fixed point with OUT_FRAC_BITS
// fraction bits, rounded to nearest with ties away from zero and saturated to
// 21 bits signed, plus a 3-bit mask of axes forced to zero (overflow code, zero
// hall value or reference, zero Z trims, vanishing Z divisor). Trim words live
// in eight 16-bit registers on the APB-style cfg_ port at byte address 4*index;
// write them only while no reading is in flight. The datapath is a pipeline
// that takes one reading per clock and holds 28 transfers in flight: five
// stages of multiply and add build the numerators, each axis then runs
// through a 22-stage one-bit-per-stage divider (21 quotient bits plus an
// overflow check), and a final register rounds off the sign and saturation.
// The whole pipeline holds only when a finished result waits at the output
// with ready low.
`timescale 1ns / 1ps
`include "magnetometer_trim_compensation_core_assert.svh"
module magnetometer_trim_compensation_core #(
  parameter int OUT_FRAC_BITS = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mtc_in_if.sink                          in_ch,
  mtc_out_if.source                       out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [mtc_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [mtc_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [mtc_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import mtc_pkg::*;

  // xy divisor is hall^2 * 2^S; the 2^S part is taken off by a shift first
  localparam int S     = 17 - OUT_FRAC_BITS;
  localparam int ZSH   = 9 + OUT_FRAC_BITS;
  localparam int DW_XY = 64 - S;
  localparam int DW_Z  = 44 + OUT_FRAC_BITS;
  localparam int NV    = OUT_W + 7;

  // ---------------------------------------------------------------- config
  cfg_reg_t cfg_reg_r [NUM_REGS];
  reg_idx_t cfg_idx;
  logic     cfg_wr;

  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = CFG_DATA_W'(cfg_reg_r[cfg_idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_reg_r[i] <= '0;
    end else if (cfg_wr) begin
      cfg_reg_r[cfg_idx] <= cfg_pwdata[REG_W-1:0];
    end
  end

  cfg_reg_t                hall_ref;
  cfg_reg_t                z1;
  logic signed [REG_W-1:0] z2;
  logic signed [REG_W-1:0] z3;
  logic signed [REG_W-1:0] z4;
  logic signed [7:0]       xy2;
  logic [7:0]              xy1;
  logic signed [7:0]       off_x;
  logic signed [7:0]       off_y;
  logic signed [10:0]      gain_x;
  logic signed [10:0]      gain_y;

  assign hall_ref = cfg_reg_r[REG_HALL_REFERENCE];
  assign z1       = cfg_reg_r[REG_Z_HALL_SLOPE];
  assign z2       = $signed(cfg_reg_r[REG_Z_DIVISOR_BASE]);
  assign z3       = $signed(cfg_reg_r[REG_Z_HALL_OFFSET_GAIN]);
  assign z4       = $signed(cfg_reg_r[REG_Z_OFFSET]);
  assign xy1      = cfg_reg_r[REG_XY_CURVATURE][7:0];
  assign xy2      = $signed(cfg_reg_r[REG_XY_CURVATURE][15:8]);
  assign off_x    = $signed(cfg_reg_r[REG_XY_OFFSETS][7:0]);
  assign off_y    = $signed(cfg_reg_r[REG_XY_OFFSETS][15:8]);
  assign gain_x   = 11'($signed(cfg_reg_r[REG_XY_GAINS][7:0])) + GAIN_BIAS;
  assign gain_y   = 11'($signed(cfg_reg_r[REG_XY_GAINS][15:8])) + GAIN_BIAS;

  // ---------------------------------------------------------------- flow control
  logic [NV-1:0] vld_r;
  logic          en;

  // every stage moves together unless the output holds a result not taken
  assign en           = !vld_r[NV-1] || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = vld_r[NV-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NV-2:0], in_ch.valid};
    end
  end

  // ---------------------------------------------------------------- stage 1
  // hall terms: d = reference - hall, d^2, d*hall, hall^2; z divisor and offset
  logic [HALL_W-1:0]   hall;
  logic signed [17:0]  d_nxt;
  logic signed [35:0]  dsq_full;
  logic signed [32:0]  dh_full;
  logic [29:0]         z1h;
  logic signed [33:0]  zpd_full;
  logic                hall_zero;
  logic [FLAG_W-1:0]   zero_nxt;

  logic signed [RAW_XY_W-1:0] s1_raw_x_r, s1_raw_y_r;
  logic [H2_W-1:0]            s1_h2_r;
  logic [31:0]                s1_dsq_r;
  logic signed [31:0]         s1_dh_r;
  logic signed [32:0]         s1_zden_r;
  logic signed [31:0]         s1_zpd_r;
  logic signed [16:0]         s1_zm_r;
  logic [FLAG_W-1:0]          s1_zero_r;

  assign hall      = in_ch.hall_resistance;
  assign d_nxt     = $signed({2'b00, hall_ref}) - $signed({4'b0000, hall});
  assign dsq_full  = d_nxt * d_nxt;
  assign dh_full   = d_nxt * $signed({1'b0, hall});
  assign z1h       = z1 * hall;
  assign zpd_full  = z3 * d_nxt;
  assign hall_zero = (hall == '0) || (hall_ref == '0);

  always_comb begin
    zero_nxt[0] = (in_ch.raw_x == XY_OVF_CODE) || hall_zero;
    zero_nxt[1] = (in_ch.raw_y == XY_OVF_CODE) || hall_zero;
    zero_nxt[2] = (in_ch.raw_z == Z_OVF_CODE) || (z2 == '0) || (z1 == '0) || hall_zero;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_raw_x_r <= in_ch.raw_x;
      s1_raw_y_r <= in_ch.raw_y;
      s1_h2_r    <= hall * hall;
      s1_dsq_r   <= dsq_full[31:0];
      s1_dh_r    <= dh_full[31:0];
      s1_zden_r  <= $signed({{2{z2[REG_W-1]}}, z2, 15'b0}) + $signed({3'b000, z1h});
      s1_zpd_r   <= zpd_full[31:0];
      s1_zm_r    <= $signed({{2{in_ch.raw_z[RAW_Z_W-1]}}, in_ch.raw_z})
                    - $signed({z4[REG_W-1], z4});
      s1_zero_r  <= zero_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // sensitivity n = xy2*d^2 + xy1*d*hall + 256*hall^2 (shared by x and y)
  logic signed [40:0] t_quad;
  logic signed [40:0] t_lin;
  logic signed [35:0] zbase_nxt;
  logic               dneg;
  logic [32:0]        dabs_full;

  logic signed [RAW_XY_W-1:0] s2_raw_x_r, s2_raw_y_r;
  logic [H2_W-1:0]            s2_h2_r;
  logic signed [41:0]         s2_n_r;
  logic signed [35:0]         s2_zbase_r;
  logic [ZDEN_W-1:0]          s2_dabs_r;
  logic                       s2_zneg_r;
  logic [FLAG_W-1:0]          s2_zero_r;

  assign t_quad    = xy2 * $signed({1'b0, s1_dsq_r});
  assign t_lin     = $signed({1'b0, xy1}) * s1_dh_r;
  assign zbase_nxt = $signed({{2{s1_zm_r[16]}}, s1_zm_r, 17'b0}) + 36'(s1_zpd_r);
  assign dneg      = s1_zden_r[32];
  assign dabs_full = dneg ? 33'(-s1_zden_r) : 33'(s1_zden_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_raw_x_r <= s1_raw_x_r;
      s2_raw_y_r <= s1_raw_y_r;
      s2_h2_r    <= s1_h2_r;
      s2_n_r     <= 42'(t_quad) + 42'(t_lin) + $signed({6'b0, s1_h2_r, 8'b0});
      s2_zbase_r <= zbase_nxt;
      s2_dabs_r  <= dabs_full[ZDEN_W-1:0];
      s2_zneg_r  <= zbase_nxt[35] ^ dneg;
      s2_zero_r  <= {s1_zero_r[2] || (s1_zden_r == '0), s1_zero_r[1:0]};
    end
  end

  // ---------------------------------------------------------------- stage 3
  // raw*n per axis, offset*hall^2, z dividend with rounding half added
  logic [35:0] zabs;

  logic signed [54:0]     s3_px_r, s3_py_r;
  logic signed [36:0]     s3_ox_r, s3_oy_r;
  logic [H2_W-1:0]        s3_h2_r;
  logic [DW_Z-1:0]        s3_zy_r;
  logic [ZDEN_W-1:0]      s3_dabs_r;
  logic                   s3_zneg_r;
  logic [FLAG_W-1:0]      s3_zero_r;

  assign zabs = s2_zbase_r[35] ? 36'(-s2_zbase_r) : 36'(s2_zbase_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_px_r   <= s2_raw_x_r * s2_n_r;
      s3_py_r   <= s2_raw_y_r * s2_n_r;
      s3_ox_r   <= off_x * $signed({1'b0, s2_h2_r});
      s3_oy_r   <= off_y * $signed({1'b0, s2_h2_r});
      s3_h2_r   <= s2_h2_r;
      s3_zy_r   <= (DW_Z'(zabs[34:0]) << ZSH) + DW_Z'(s2_dabs_r >> 1);
      s3_dabs_r <= s2_dabs_r;
      s3_zneg_r <= s2_zneg_r;
      s3_zero_r <= s2_zero_r;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // full xy numerator: raw*n*(gain+160) + offset*8*8192*hall^2
  logic signed [65:0] px_g, py_g, sum_x, sum_y;

  logic signed [63:0] s4_numx_r, s4_numy_r;
  logic [H2_W-1:0]    s4_h2_r;
  logic [DW_Z-1:0]    s4_zy_r;
  logic [ZDEN_W-1:0]  s4_dabs_r;
  logic               s4_zneg_r;
  logic [FLAG_W-1:0]  s4_zero_r;

  assign px_g  = s3_px_r * gain_x;
  assign py_g  = s3_py_r * gain_y;
  assign sum_x = px_g + 66'($signed({s3_ox_r, 16'b0}));
  assign sum_y = py_g + 66'($signed({s3_oy_r, 16'b0}));

  always_ff @(posedge clk) begin
    if (en) begin
      s4_numx_r <= sum_x[63:0];
      s4_numy_r <= sum_y[63:0];
      s4_h2_r   <= s3_h2_r;
      s4_zy_r   <= s3_zy_r;
      s4_dabs_r <= s3_dabs_r;
      s4_zneg_r <= s3_zneg_r;
      s4_zero_r <= s3_zero_r;
    end
  end

  // ---------------------------------------------------------------- stage 5
  // magnitude plus half divisor, then drop the power-of-two part of the divisor
  logic [63:0] magx, magy, yx_sum, yy_sum;

  logic [DW_XY-1:0]  s5_yx_r, s5_yy_r;
  logic [H2_W-1:0]   s5_h2_r;
  logic [DW_Z-1:0]   s5_zy_r;
  logic [ZDEN_W-1:0] s5_dabs_r;
  mtc_side_t         s5_sx_r, s5_sy_r, s5_sz_r;

  assign magx   = s4_numx_r[63] ? 64'(-s4_numx_r) : 64'(s4_numx_r);
  assign magy   = s4_numy_r[63] ? 64'(-s4_numy_r) : 64'(s4_numy_r);
  assign yx_sum = magx + (64'(s4_h2_r) << (S - 1));
  assign yy_sum = magy + (64'(s4_h2_r) << (S - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      s5_yx_r   <= yx_sum[63:S];
      s5_yy_r   <= yy_sum[63:S];
      s5_h2_r   <= s4_h2_r;
      s5_zy_r   <= s4_zy_r;
      s5_dabs_r <= s4_dabs_r;
      s5_sx_r   <= '{neg: s4_numx_r[63], zero: s4_zero_r[0]};
      s5_sy_r   <= '{neg: s4_numy_r[63], zero: s4_zero_r[1]};
      s5_sz_r   <= '{neg: s4_zneg_r, zero: s4_zero_r[2]};
    end
  end

  // ---------------------------------------------------------------- dividers
  logic [OUT_W-1:0] qx, qy, qz;
  logic             satx, saty, satz;
  mtc_side_t        sidex, sidey, sidez;

  mtc_div #(.DW(DW_XY), .VW(H2_W), .QW(OUT_W)) u_div_x (
    .clk(clk), .en(en), .dvd(s5_yx_r), .dvs(s5_h2_r), .side_in(s5_sx_r),
    .quo(qx), .sat(satx), .side_out(sidex)
  );

  mtc_div #(.DW(DW_XY), .VW(H2_W), .QW(OUT_W)) u_div_y (
    .clk(clk), .en(en), .dvd(s5_yy_r), .dvs(s5_h2_r), .side_in(s5_sy_r),
    .quo(qy), .sat(saty), .side_out(sidey)
  );

  mtc_div #(.DW(DW_Z), .VW(ZDEN_W), .QW(OUT_W)) u_div_z (
    .clk(clk), .en(en), .dvd(s5_zy_r), .dvs(s5_dabs_r), .side_in(s5_sz_r),
    .quo(qz), .sat(satz), .side_out(sidez)
  );

  // ---------------------------------------------------------------- output
  // apply sign, saturate to 21 bits, force zero on flagged axes
  function automatic logic signed [OUT_W-1:0] shape_field(
    input logic [OUT_W-1:0] q,
    input logic             ovf,
    input mtc_side_t        side
  );
    logic signed [OUT_W-1:0] res;
    if (side.zero) begin
      res = '0;
    end else if (!side.neg) begin
      res = (ovf || q[OUT_W-1]) ? OUT_MAX : $signed(q);
    end else begin
      res = (ovf || (q[OUT_W-1] && (q[OUT_W-2:0] != '0))) ? OUT_MIN : $signed(-q);
    end
    return res;
  endfunction

  logic signed [OUT_W-1:0] field_x_r, field_y_r, field_z_r;
  logic [FLAG_W-1:0]       zeroed_r;

  always_ff @(posedge clk) begin
    if (en) begin
      field_x_r <= shape_field(qx, satx, sidex);
      field_y_r <= shape_field(qy, saty, sidey);
      field_z_r <= shape_field(qz, satz, sidez);
      zeroed_r  <= {sidez.zero, sidey.zero, sidex.zero};
    end
  end

  assign out_ch.field_x     = field_x_r;
  assign out_ch.field_y     = field_y_r;
  assign out_ch.field_z     = field_z_r;
  assign out_ch.zeroed_axes = zeroed_r;

  // ---------------------------------------------------------------- checks
  `MTC_ASSERT_IMP(a_stall_needs_backpressure, !in_ch.ready, out_ch.valid && !out_ch.ready, "input stalled without output backpressure")
  `MTC_ASSERT_NXT(a_last_stage_reaches_out, en && vld_r[NV-2], out_ch.valid, "result lost before output register")
  `MTC_ASSERT_IMP(a_zero_x_flag, out_ch.valid && out_ch.zeroed_axes[0], out_ch.field_x == '0, "x flagged zero but nonzero")
  `MTC_ASSERT_IMP(a_zero_z_flag, out_ch.valid && out_ch.zeroed_axes[2], out_ch.field_z == '0, "z flagged zero but nonzero")
endmodule

[bench/tb_magnetometer_trim_compensation_core.sv]
// self-checking testbench for the magnetometer trim compensation core
`timescale 1ns / 1ps
module tb_magnetometer_trim_compensation_core;
  import mtc_pkg::*;

  localparam int FRAC       = 4;
  localparam int DRAIN_WAIT = 40;    // wait for the pipeline to empty, with margin
  localparam int IDLE_LIMIT = 5000;  // cycles without any transfer
  localparam int N_PHASES   = 8;
  localparam int N_RANDOM   = 225;   // readings per random phase

  typedef struct {
    logic [OUT_W-1:0]  fx;
    logic [OUT_W-1:0]  fy;
    logic [OUT_W-1:0]  fz;
    logic [FLAG_W-1:0] zeroed;
  } field_set_t;

  // directed rows: typed rows carry all-zero fields and the given mask
  typedef struct packed {
    logic [RAW_XY_W-1:0] rx;
    logic [RAW_XY_W-1:0] ry;
    logic [RAW_Z_W-1:0]  rz;
    logic [HALL_W-1:0]   hall;
    logic                typed;
    logic [FLAG_W-1:0]   zeroed;
  } reading_row_t;

  localparam int N_ROWS = 22;
  localparam int N_RESET_ROWS = 6;
  // first rows run with registers at reset (zero reference: everything zeroed)
  localparam reading_row_t DIRECTED [N_ROWS] = '{
    '{13'h0fff, 13'h0fff, 15'h3fff, 14'h3fff, 1'b1, 3'd7},
    '{13'h1000, 13'h1000, 15'h4000, 14'h0000, 1'b1, 3'd7},
    '{13'h1001, 13'h1fff, 15'h4001, 14'h0001, 1'b1, 3'd7},
    '{13'h0000, 13'h0000, 15'h0000, 14'h2000, 1'b1, 3'd7},
    '{13'h0aaa, 13'h1555, 15'h2aaa, 14'h1555, 1'b1, 3'd7},
    '{13'h1555, 13'h0aaa, 15'h5555, 14'h2aaa, 1'b1, 3'd7},
    // trimmed rows, checked against the predictor unless typed
    '{13'h0fff, 13'h0fff, 15'h3fff, 14'h1a2b, 1'b0, 3'd0},
    '{13'h1001, 13'h1001, 15'h4001, 14'h1a2b, 1'b0, 3'd0},
    '{13'h1000, 13'h0123, 15'h0456, 14'h1000, 1'b0, 3'd0},
    '{13'h0321, 13'h1000, 15'h0456, 14'h1000, 1'b0, 3'd0},
    '{13'h0321, 13'h0123, 15'h4000, 14'h1000, 1'b0, 3'd0},
    '{13'h1000, 13'h1000, 15'h4000, 14'h1000, 1'b0, 3'd0},
    '{13'h0fff, 13'h1001, 15'h3fff, 14'h0000, 1'b1, 3'd7},
    '{13'h0fff, 13'h1001, 15'h3fff, 14'h0001, 1'b0, 3'd0}, // z divisor vanishes
    '{13'h0fff, 13'h1001, 15'h4001, 14'h3fff, 1'b0, 3'd0},
    '{13'h1001, 13'h0fff, 15'h3fff, 14'h3fff, 1'b0, 3'd0},
    '{13'h0000, 13'h0000, 15'h0000, 14'h0002, 1'b0, 3'd0},
    '{13'h0001, 13'h1fff, 15'h0001, 14'h1a2b, 1'b0, 3'd0},
    '{13'h0fff, 13'h0fff, 15'h3fff, 14'h0fff, 1'b0, 3'd0},
    '{13'h1001, 13'h1001, 15'h4001, 14'h2fff, 1'b0, 3'd0},
    '{13'h0aaa, 13'h1555, 15'h2aaa, 14'h1555, 1'b0, 3'd0},
    '{13'h1555, 13'h0aaa, 15'h5555, 14'h2aaa, 1'b0, 3'd0}
  };

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  mtc_in_if  in_if ();
  mtc_out_if out_if ();

  magnetometer_trim_compensation_core #(.OUT_FRAC_BITS(FRAC)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // shadow of the trim registers, used by the predictor
  cfg_reg_t trim [NUM_REGS];

  field_set_t pending_fields [$];
  logic       row_typed;        // sideband: current reading has a typed result
  logic [FLAG_W-1:0] row_zeroed;

  int mismatches;
  int readings_in;
  int results_out;
  int zeroed_seen;
  int saturated_seen;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic [OUT_W-1:0] clamp21(longint v);
    if (v > 1048575) v = 1048575;
    if (v < -1048576) v = -1048576;
    return v[OUT_W-1:0];
  endfunction

  // x or y axis: quadratic hall sensitivity, gain and offset trims
  function automatic bit xy_axis(longint raw, longint hall, longint off, longint gain,
                                 output longint res);
    longint ref_h, lin, quad, d, h2, n, num;
    ref_h = longint'(trim[REG_HALL_REFERENCE]);
    lin   = longint'(trim[REG_XY_CURVATURE][7:0]);
    quad  = longint'($signed(trim[REG_XY_CURVATURE][15:8]));
    res = 0;
    if (raw == -4096 || hall == 0 || ref_h == 0) return 1'b1;
    d   = ref_h - hall;
    h2  = hall * hall;
    n   = quad * d * d + lin * d * hall + 256 * h2;
    num = raw * n * (gain + 160) + off * 8 * 8192 * h2;
    res = round_div(num, h2 * (longint'(1) << (17 - FRAC)));
    return 1'b0;
  endfunction

  // z axis: offset, hall offset gain and hall-dependent divisor
  function automatic bit z_axis(longint raw, longint hall, output longint res);
    longint ref_h, slope, base, hgain, zoff, numz, den;
    ref_h = longint'(trim[REG_HALL_REFERENCE]);
    slope = longint'(trim[REG_Z_HALL_SLOPE]);
    base  = longint'($signed(trim[REG_Z_DIVISOR_BASE]));
    hgain = longint'($signed(trim[REG_Z_HALL_OFFSET_GAIN]));
    zoff  = longint'($signed(trim[REG_Z_OFFSET]));
    res = 0;
    if (raw == -16384 || base == 0 || slope == 0 || ref_h == 0 || hall == 0)
      return 1'b1;
    den = base * 32768 + slope * hall;
    if (den == 0) return 1'b1;
    numz = ((raw - zoff) * 131072 - hgain * (hall - ref_h)) * 512 * (longint'(1) << FRAC);
    if (den < 0) begin
      den  = -den;
      numz = -numz;
    end
    res = round_div(numz, den);
    return 1'b0;
  endfunction

  function automatic field_set_t compensate(logic [RAW_XY_W-1:0] rx, logic [RAW_XY_W-1:0] ry,
                                            logic [RAW_Z_W-1:0] rz, logic [HALL_W-1:0] hall);
    field_set_t r;
    longint vx, vy, vz, h;
    h = longint'(hall);
    r.zeroed = '0;
    r.zeroed[0] = xy_axis(longint'($signed(rx)), h, longint'($signed(trim[REG_XY_OFFSETS][7:0])),
                          longint'($signed(trim[REG_XY_GAINS][7:0])), vx);
    r.zeroed[1] = xy_axis(longint'($signed(ry)), h, longint'($signed(trim[REG_XY_OFFSETS][15:8])),
                          longint'($signed(trim[REG_XY_GAINS][15:8])), vy);
    r.zeroed[2] = z_axis(longint'($signed(rz)), h, vz);
    r.fx = clamp21(vx);
    r.fy = clamp21(vy);
    r.fz = clamp21(vz);
    return r;
  endfunction

  // ------------------------------------------------- input transfer monitor
  always @(posedge clk) begin
    field_set_t e;
    if (rst_n && in_if.valid && in_if.ready) begin
      if (row_typed) begin
        e.fx = '0;
        e.fy = '0;
        e.fz = '0;
        e.zeroed = row_zeroed;
      end else begin
        e = compensate(in_if.raw_x, in_if.raw_y, in_if.raw_z, in_if.hall_resistance);
      end
      pending_fields.push_back(e);
      readings_in++;
    end
  end

  // ------------------------------------------------ result transfer checker
  always @(posedge clk) begin
    field_set_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_out++;
      if (out_if.zeroed_axes != 0) zeroed_seen++;
      if (out_if.field_x == OUT_MAX || out_if.field_x == OUT_MIN) saturated_seen++;
      if (pending_fields.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
      end else begin
        e = pending_fields.pop_front();
        if (out_if.field_x !== e.fx || out_if.field_y !== e.fy ||
            out_if.field_z !== e.fz || out_if.zeroed_axes !== e.zeroed) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: exp x=%0d y=%0d z=%0d zeroed=%b, got x=%0d y=%0d z=%0d zeroed=%b",
                     $realtime, $signed(e.fx), $signed(e.fy), $signed(e.fz), e.zeroed,
                     out_if.field_x, out_if.field_y, out_if.field_z, out_if.zeroed_axes);
        end
      end
    end
  end

  // result side back-pressure: mostly short stalls, now and then a long one
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0:       stall_left <= $urandom_range(10, 50);
        1, 2, 3: stall_left <= $urandom_range(0, 3);
        default: stall_left <= 0;
      endcase
      out_if.ready <= 1'b1;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------- config access
  task automatic write_trim(reg_idx_t idx, cfg_reg_t value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(4 * int'(idx));
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    trim[idx]   = value;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    // read back
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata[REG_W-1:0] !== value) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register %s read back %h, exp %h", idx.name(), cfg_prdata[REG_W-1:0], value);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic write_all(cfg_reg_t v [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) write_trim(reg_idx_t'(i), v[i]);
  endtask

  task automatic drain();
    while (pending_fields.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // --------------------------------------------------------------- sender
  task automatic send_reading(logic [RAW_XY_W-1:0] rx, logic [RAW_XY_W-1:0] ry,
                              logic [RAW_Z_W-1:0] rz, logic [HALL_W-1:0] hall,
                              logic typed, logic [FLAG_W-1:0] zeroed);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    gap = (pick < 65) ? 0 : (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid           <= 1'b1;
    in_if.raw_x           <= rx;
    in_if.raw_y           <= ry;
    in_if.raw_z           <= rz;
    in_if.hall_resistance <= hall;
    row_typed             <= typed;
    row_zeroed            <= zeroed;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic stop_sending();
    in_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [RAW_XY_W-1:0] pick_xy();
    case ($urandom_range(0, 15))
      0:       return XY_OVF_CODE;
      1:       return 13'h0fff;
      2:       return 13'h1001;
      default: return RAW_XY_W'($urandom);
    endcase
  endfunction

  function automatic logic [RAW_Z_W-1:0] pick_z();
    case ($urandom_range(0, 15))
      0:       return Z_OVF_CODE;
      1:       return 15'h3fff;
      2:       return 15'h4001;
      default: return RAW_Z_W'($urandom);
    endcase
  endfunction

  // hall readings mostly sit near the reference, as a real sensor's do
  function automatic logic [HALL_W-1:0] pick_hall();
    int h;
    case ($urandom_range(0, 31))
      0:       return '0;
      1, 2:    return 14'h3fff;
      3, 4, 5: return HALL_W'($urandom);
      default: begin
        h = int'(trim[REG_HALL_REFERENCE]) + $urandom_range(0, 1023) - 512;
        if (h < 1) h = 1;
        if (h > 16383) h = 16383;
        return HALL_W'(h);
      end
    endcase
  endfunction

  task automatic random_trims(int phase);
    cfg_reg_t v [NUM_REGS];
    for (int i = 0; i < NUM_REGS; i++) v[i] = REG_W'($urandom);
    case (phase)
      1: for (int i = 0; i < NUM_REGS; i++) v[i] = 16'hffff;
      2: v = '{16'h8080, 16'h8080, 16'h80ff, 16'h3fff, 16'hffff, 16'h8000, 16'h8000, 16'h7fff};
      3: v = '{16'h7f7f, 16'h7f7f, 16'h7f00, 16'h0001, 16'h0001, 16'h7fff, 16'h7fff, 16'h8000};
      default: begin
        v[REG_HALL_REFERENCE] = $urandom_range(0, 15) == 0 ? 16'h0000 :
                                REG_W'($urandom_range(1000, 16383));
        if ($urandom_range(0, 5) == 0) v[REG_Z_DIVISOR_BASE] = '0;
        if ($urandom_range(0, 5) == 0) v[REG_Z_HALL_SLOPE] = '0;
      end
    endcase
    write_all(v);
  endtask

  // ------------------------------------------------------------ main flow
  initial begin
    cfg_reg_t bent [NUM_REGS];
    reading_row_t r;
    rst_n       = 1'b0;
    mismatches  = 0;
    readings_in = 0;
    results_out = 0;
    zeroed_seen = 0;
    saturated_seen = 0;
    idle_cycles = 0;
    for (int i = 0; i < NUM_REGS; i++) trim[i] = '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    in_if.valid <= 1'b0;
    in_if.raw_x <= '0;
    in_if.raw_y <= '0;
    in_if.raw_z <= '0;
    in_if.hall_resistance <= '0;
    row_typed   <= 1'b0;
    row_zeroed  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: registers at reset first, then a trim set whose z divisor
    // vanishes at hall = 1
    bent = '{16'h7f80, 16'h807f, 16'h80ff, 16'h1a2b, 16'h8000, 16'hffff, 16'h7fff, 16'h8000};
    for (int i = 0; i < N_ROWS; i++) begin
      if (i == N_RESET_ROWS) begin
        stop_sending();
        drain();
        write_all(bent);
      end
      r = DIRECTED[i];
      send_reading(r.rx, r.ry, r.rz, r.hall, r.typed, r.zeroed);
    end
    stop_sending();
    drain();

    // random phases, each under its own trim set
    for (int p = 1; p <= N_PHASES; p++) begin
      random_trims(p);
      for (int n = 0; n < N_RANDOM; n++) begin
        // hold the sender once until the pipeline has emptied
        if (p == 4 && n == N_RANDOM / 2) begin
          stop_sending();
          while (pending_fields.size() != 0) @(posedge clk);
        end
        send_reading(pick_xy(), pick_xy(), pick_z(), pick_hall(), 1'b0, '0);
      end
      stop_sending();
      drain();
    end

    $display("readings sent %0d, results checked %0d (%0d with zeroed axes, %0d x saturated)",
             readings_in, results_out, zeroed_seen, saturated_seen);
    $display("%0d trim sets applied, including all-ones, sign extremes and a vanishing z divisor",
             N_PHASES + 2);
    if (mismatches == 0 && pending_fields.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, pending_fields.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[magnetometer_trim_compensation_core.f]
+incdir+design
design/mtc_pkg.sv
design/mtc_if.sv
design/mtc_div.sv
design/magnetometer_trim_compensation_core.sv
bench/tb_magnetometer_trim_compensation_core.sv
